>>> hdl/bpc_pkg.sv
// Shared types, constants and helpers for the pressure compensation block.
package bpc_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [CFG_IDX_W-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B1_B2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MC_MD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OSS = 3'd5;

    localparam logic [31:0] B6_OFFSET = 32'd4000;
    localparam logic [31:0] B4_BIAS = 32'd32768;
    localparam logic [31:0] B7_SCALE = 32'd50000;
    localparam logic [31:0] SIGN_BIT = 32'h8000_0000;
    localparam logic [31:0] P_C1 = 32'd3038;
    localparam logic [31:0] P_C2 = 32'hFFFF_E343; // -7357
    localparam logic [31:0] P_C3 = 32'd3791;
    localparam logic [31:0] T_ROUND = 32'd8;

    typedef struct packed {
        logic signed [15:0] ac1, ac2, ac3;
        logic [15:0] ac4, ac5, ac6;
        logic signed [15:0] b1, b2, mc, md;
        logic [1:0] oss;
    } cal_t;

    // word handed from front to back
    typedef struct packed {
        logic [18:0] up;
        logic [31:0] x1;
        logic [31:0] den;
        logic [31:0] num;
    } front_word_t;

    function automatic logic [31:0] asr(input logic [31:0] v, input int s);
        asr = 32'($signed(v) >>> s);
    endfunction

    function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] f;
        f = 64'(a) * 64'(b);
        mul = f[31:0];
    endfunction

endpackage

>>> hdl/bpc_div.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
module bpc_div import bpc_pkg::*; #(
    parameter int TAG_W = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [31:0]      in_num,
    input  logic [31:0]      in_den,
    input  logic [TAG_W-1:0] in_tag,
    output logic             out_valid,
    output logic [31:0]      out_quo,
    output logic [TAG_W-1:0] out_tag
);
    localparam int N = 32;
    logic [N:1]       vld_reg;
    logic [31:0]      rem_reg [1:N];
    logic [31:0]      quo_reg [1:N];
    logic [31:0]      den_reg [1:N];
    logic [TAG_W-1:0] tag_reg [1:N];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic             vld_in;
        logic [31:0]      rem_in;
        logic [31:0]      quo_in;
        logic [31:0]      den_in;
        logic [TAG_W-1:0] tag_in;
        logic [32:0]      trial;
        logic [32:0]      shifted;

        // first stage takes the input word, later ones the previous stage
        if (i == 0) begin : g_first
            assign vld_in = in_valid;
            assign rem_in = '0;
            assign quo_in = in_num;
            assign den_in = in_den;
            assign tag_in = in_tag;
        end else begin : g_next
            assign vld_in = vld_reg[i];
            assign rem_in = rem_reg[i];
            assign quo_in = quo_reg[i];
            assign den_in = den_reg[i];
            assign tag_in = tag_reg[i];
        end

        assign shifted = {rem_in, quo_in[31]};
        assign trial = shifted - {1'b0, den_in};
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i+1] <= 1'b0;
            end else if (en) begin
                vld_reg[i+1] <= vld_in;
            end
            if (en) begin
                den_reg[i+1] <= den_in;
                tag_reg[i+1] <= tag_in;
                if (!trial[32]) begin
                    rem_reg[i+1] <= trial[31:0];
                    quo_reg[i+1] <= {quo_in[30:0], 1'b1};
                end else begin
                    rem_reg[i+1] <= shifted[31:0];
                    quo_reg[i+1] <= {quo_in[30:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[N];
    assign out_quo = quo_reg[N];
    assign out_tag = tag_reg[N];
endmodule

>>> hdl/bpc_front.sv
// Front end: temperature term x1 and the temperature divisor, registered.
module bpc_front import bpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cal_t        cal,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_raw_temperature,
    input  logic [18:0] s_raw_pressure,
    output logic        f_valid,
    input  logic        f_ready,
    output front_word_t f_word
);
    logic        v_reg;
    front_word_t w_reg;
    logic [31:0] x1_c;

    assign x1_c = asr(mul({16'd0, s_raw_temperature} - {16'd0, cal.ac6},
                          {16'd0, cal.ac5}), 15);
    assign s_ready = !v_reg || f_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (s_ready) begin
            v_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            w_reg.up  <= s_raw_pressure;
            w_reg.x1  <= x1_c;
            w_reg.den <= x1_c + 32'(cal.md);
            w_reg.num <= 32'(cal.mc) << 11;
        end
    end

    assign f_valid = v_reg;
    assign f_word = w_reg;
endmodule

>>> hdl/bpc_queue.sv
// Small FIFO between the front and back ends.
module bpc_queue import bpc_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  front_word_t in_word,
    output logic        out_valid,
    input  logic        out_ready,
    output front_word_t out_word
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    front_word_t        mem_reg [DEPTH];
    logic [AW-1:0]      wp_reg, rp_reg;
    logic [AW:0]        cnt_reg;
    logic               wr, rd;

    assign in_ready = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;
    assign out_word = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            if (rd) rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(wr) - (AW+1)'(rd);
        end
        if (wr) mem_reg[wp_reg] <= in_word;
    end
endmodule

>>> hdl/bpc_back.sv
// Back end: pipelined divisions, pressure arithmetic and output register.
module bpc_back import bpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cal_t        cal,
    input  logic        q_valid,
    output logic        q_ready,
    input  front_word_t q_word,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [15:0] m_temperature_dc,
    output logic signed [31:0] m_pressure_pa,
    output logic        m_div_fault
);
    localparam int TAG1_W = 19 + 32 + 1 + 1 + 1;
    localparam int TAG2_W = 16 + 1 + 1;

    // Whole pipe stalls together; it may only move when the output can take.
    logic en;
    logic out_v_reg;
    assign en = !out_v_reg || m_ready;
    assign q_ready = en;

    logic        fault0;
    logic [31:0] an, ad;
    assign fault0 = q_word.den == '0;
    assign an = q_word.num[31] ? -q_word.num : q_word.num;
    assign ad = q_word.den[31] ? -q_word.den : q_word.den;

    logic              d1_v;
    logic [31:0]       d1_q;
    logic [TAG1_W-1:0] d1_t;
    bpc_div #(.TAG_W(TAG1_W)) u_div_t (
        .aclk, .aresetn, .en,
        .in_valid(q_valid),
        .in_num(an), .in_den(fault0 ? 32'd1 : ad),
        .in_tag({q_word.up, q_word.x1, q_word.num[31] ^ q_word.den[31], fault0, 1'b0}),
        .out_valid(d1_v), .out_quo(d1_q), .out_tag(d1_t)
    );

    // stage A: b5 and b6
    logic [18:0] a_up;
    logic        a_f;
    logic        a_v;
    logic [31:0] a_b5, a_b6;
    logic [31:0] x2t;
    assign x2t = d1_t[2] ? -d1_q : d1_q;
    always_ff @(posedge aclk) begin
        if (!aresetn) a_v <= 1'b0;
        else if (en) a_v <= d1_v;
        if (en) begin
            a_up <= d1_t[TAG1_W-1 -: 19];
            a_f  <= d1_t[1];
            a_b5 <= d1_t[34:3] + x2t;
            a_b6 <= d1_t[34:3] + x2t - B6_OFFSET;
        end
    end

    // stage B: products on b6
    logic        b_v, b_f;
    logic [18:0] b_up;
    logic [31:0] b_b5, b_sq, b_ac2b6, b_ac3b6;
    always_ff @(posedge aclk) begin
        if (!aresetn) b_v <= 1'b0;
        else if (en) b_v <= a_v;
        if (en) begin
            b_f <= a_f; b_up <= a_up; b_b5 <= a_b5;
            b_sq <= asr(mul(a_b6, a_b6), 12);
            b_ac2b6 <= asr(mul(32'(cal.ac2), a_b6), 11);
            b_ac3b6 <= asr(mul(32'(cal.ac3), a_b6), 13);
        end
    end

    // stage C: products on sq
    logic        c_v, c_f;
    logic [18:0] c_up;
    logic [31:0] c_b5, c_x3a, c_x1b, c_x2b;
    always_ff @(posedge aclk) begin
        if (!aresetn) c_v <= 1'b0;
        else if (en) c_v <= b_v;
        if (en) begin
            c_f <= b_f; c_up <= b_up; c_b5 <= b_b5;
            c_x3a <= asr(mul(32'(cal.b2), b_sq), 11) + b_ac2b6;
            c_x1b <= b_ac3b6;
            c_x2b <= asr(mul(32'(cal.b1), b_sq), 16);
        end
    end

    // stage D: b3 and x3
    logic        d_v, d_f;
    logic [18:0] d_up;
    logic [31:0] d_b5, d_b3, d_x3;
    always_ff @(posedge aclk) begin
        if (!aresetn) d_v <= 1'b0;
        else if (en) d_v <= c_v;
        if (en) begin
            d_f <= c_f; d_up <= c_up; d_b5 <= c_b5;
            d_b3 <= asr((((32'(cal.ac1) << 2) + c_x3a) << cal.oss) + 32'd2, 2);
            d_x3 <= asr(c_x1b + c_x2b + 32'd2, 2);
        end
    end

    // stage E: b4 and b7
    logic        e_v, e_f;
    logic [31:0] e_b5, e_b4, e_b7;
    always_ff @(posedge aclk) begin
        if (!aresetn) e_v <= 1'b0;
        else if (en) e_v <= d_v;
        if (en) begin
            e_f <= d_f; e_b5 <= d_b5;
            e_b4 <= mul({16'd0, cal.ac4}, d_x3 + B4_BIAS) >> 15;
            e_b7 <= mul({13'd0, d_up} - d_b3, B7_SCALE >> cal.oss);
        end
    end

    logic        big, fault1;
    logic [31:0] t_e;
    assign big = (e_b7 & SIGN_BIT) != '0;
    assign fault1 = e_f || (e_b4 == '0);
    assign t_e = asr(e_b5 + T_ROUND, 4);

    logic              d2_v;
    logic [31:0]       d2_q;
    logic [TAG2_W-1:0] d2_t;
    bpc_div #(.TAG_W(TAG2_W)) u_div_p (
        .aclk, .aresetn, .en,
        .in_valid(e_v),
        .in_num(big ? e_b7 : e_b7 << 1),
        .in_den(e_b4 == '0 ? 32'd1 : e_b4),
        .in_tag({t_e[15:0], big, fault1}),
        .out_valid(d2_v), .out_quo(d2_q), .out_tag(d2_t)
    );

    // stage F: p and its squared term
    logic        f_v, f_f;
    logic [15:0] f_t;
    logic [31:0] f_p, f_x1, f_x2;
    logic [31:0] p_c, p8;
    assign p_c = d2_t[1] ? d2_q << 1 : d2_q;
    assign p8 = asr(p_c, 8);
    always_ff @(posedge aclk) begin
        if (!aresetn) f_v <= 1'b0;
        else if (en) f_v <= d2_v;
        if (en) begin
            f_f <= d2_t[0]; f_t <= d2_t[TAG2_W-1 -: 16];
            f_p <= p_c;
            f_x1 <= mul(p8, p8);
            f_x2 <= asr(mul(P_C2, p_c), 16);
        end
    end

    // stage G: constant product
    logic        g_v, g_f;
    logic [15:0] g_t;
    logic [31:0] g_p, g_x1, g_x2;
    always_ff @(posedge aclk) begin
        if (!aresetn) g_v <= 1'b0;
        else if (en) g_v <= f_v;
        if (en) begin
            g_f <= f_f; g_t <= f_t; g_p <= f_p; g_x2 <= f_x2;
            g_x1 <= asr(mul(f_x1, P_C1), 16);
        end
    end

    // output register
    logic [31:0] p_fin;
    assign p_fin = g_p + asr(g_x1 + g_x2 + P_C3, 4);
    always_ff @(posedge aclk) begin
        if (!aresetn) out_v_reg <= 1'b0;
        else if (en) out_v_reg <= g_v;
        if (en) begin
            m_div_fault <= g_f;
            m_temperature_dc <= g_f ? '0 : g_t;
            m_pressure_pa <= g_f ? '0 : p_fin;
        end
    end
    assign m_valid = out_v_reg;
endmodule

>>> hdl/barometric_pressure_compensation_unit.sv
// Top level of the barometric pressure compensation unit.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | raw_temperature[15:0], raw_pressure[18:0]
//  m_      | out       | m_valid / m_ready  | temperature_dc[15:0], pressure_pa[31:0], div_fault
//  cfg     | in        | cfg_we             | cfg_index[2:0], cfg_data[31:0]
//
// One word per cycle sustained while m_ready is high. From input accept to the
// earliest output accept a word passes the front register, a queue slot, two 32-stage
// dividers (one quotient bit per stage), seven arithmetic stages and the output register.
// Reset (synchronous, aresetn low) clears all valids and zeros calibration.
// An m_ stall freezes the back pipe; the queue absorbs front words and
// s_ready drops only once the queue and front register are full.
module barometric_pressure_compensation_unit import bpc_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [15:0]           s_raw_temperature,
    input  logic [18:0]           s_raw_pressure,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic signed [15:0]    m_temperature_dc,
    output logic signed [31:0]    m_pressure_pa,
    output logic                  m_div_fault
);
    logic [31:0] r0_reg, r1_reg, r2_reg, r3_reg, r4_reg;
    logic [1:0]  oss_reg;
    cal_t        cal;

    // calibration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r0_reg <= '0; r1_reg <= '0; r2_reg <= '0;
            r3_reg <= '0; r4_reg <= '0; oss_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_AC1_AC2: r0_reg <= cfg_data;
                REG_AC3_AC4: r1_reg <= cfg_data;
                REG_AC5_AC6: r2_reg <= cfg_data;
                REG_B1_B2:   r3_reg <= cfg_data;
                REG_MC_MD:   r4_reg <= cfg_data;
                REG_OSS:     oss_reg <= cfg_data[1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cal.ac1 = r0_reg[31:16]; cal.ac2 = r0_reg[15:0];
        cal.ac3 = r1_reg[31:16]; cal.ac4 = r1_reg[15:0];
        cal.ac5 = r2_reg[31:16]; cal.ac6 = r2_reg[15:0];
        cal.b1  = r3_reg[31:16]; cal.b2  = r3_reg[15:0];
        cal.mc  = r4_reg[31:16]; cal.md  = r4_reg[15:0];
        cal.oss = oss_reg;
    end

    logic        f_valid, f_ready, q_valid, q_ready;
    front_word_t f_word, q_word;

    bpc_front u_front (
        .aclk, .aresetn, .cal,
        .s_valid, .s_ready, .s_raw_temperature, .s_raw_pressure,
        .f_valid, .f_ready, .f_word
    );

    bpc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn,
        .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
        .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
    );

    bpc_back u_back (
        .aclk, .aresetn, .cal,
        .q_valid, .q_ready, .q_word,
        .m_valid, .m_ready, .m_temperature_dc, .m_pressure_pa, .m_div_fault
    );
endmodule
